>>> sv/urldec_pkg.sv
package urldec_pkg;

    // Width of the per-string decoded byte counter
    localparam int COUNT_WIDTH = 16;
    // Width of the capacity register and of the reported length
    localparam int LEN_WIDTH   = 16;
    // Width used when the counter is compared with the capacity limit
    localparam int CMP_WIDTH   = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;

    localparam logic [7:0]           PERCENT_CHAR  = 8'h25;
    localparam logic [7:0]           NOT_HEX       = 8'd127;
    localparam logic [3:0]           NIBBLE_MASK   = 4'hf;
    localparam logic [LEN_WIDTH-1:0] CAPACITY_RST  = LEN_WIDTH'(256);

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 byte_valid;
        logic                 end_of_string;
        logic [LEN_WIDTH-1:0] out_length;
    } out_item_t;

    // Hex digit value; a non-hex character maps to the low nibble of NOT_HEX
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                v = c - 8'h30;
            end
            else if (c >= 8'h41 && c <= 8'h46) begin
                v = c - 8'h41 + 8'd10;
            end
            else if (c >= 8'h61 && c <= 8'h66) begin
                v = c - 8'h61 + 8'd10;
            end
            else begin
                v = NOT_HEX;
            end
            return v[3:0] & NIBBLE_MASK;
        end
    endfunction

endpackage

>>> sv/urldec_in_reg.sv
module urldec_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  urldec_pkg::in_item_t in_data,
    input  logic                take,
    output logic                item_valid,
    output urldec_pkg::in_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    urldec_pkg::in_item_t item_reg;
    logic                 load;

    // Hold the beat only while the decode stage cannot take it
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end
        else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (load) begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> sv/urldec_decode.sv
module urldec_decode (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  urldec_pkg::in_item_t                 item,
    input  logic [urldec_pkg::LEN_WIDTH-1:0]     capacity,
    output logic                                 res_valid,
    output urldec_pkg::out_item_t                res
);

    urldec_pkg::phase_t                     phase_reg;
    urldec_pkg::phase_t                     phase_next;
    logic [3:0]                             high_reg;
    logic [3:0]                             high_next;
    logic [urldec_pkg::COUNT_WIDTH-1:0]     count_reg;
    logic [urldec_pkg::COUNT_WIDTH-1:0]     count_next;
    logic                                   stopped_reg;
    logic                                   stopped_next;

    logic                                   have;
    logic [7:0]                             value;
    logic                                   full;
    logic                                   emit;
    logic [urldec_pkg::CMP_WIDTH-1:0]       limit;
    logic [urldec_pkg::CMP_WIDTH-1:0]       count_ext;
    logic [urldec_pkg::COUNT_WIDTH-1:0]     count_after;

    // Escape phase walk and byte value; the final byte returns to plain
    always_comb
    begin
        phase_next = phase_reg;
        high_next  = high_reg;
        have       = 1'b0;
        value      = 8'h00;
        if (!stopped_reg) begin
            unique case (phase_reg)
                urldec_pkg::PH_HIGH:
                begin
                    high_next  = urldec_pkg::hex_nibble(item.in_byte);
                    phase_next = urldec_pkg::PH_LOW;
                end
                urldec_pkg::PH_LOW:
                begin
                    value      = {high_reg, urldec_pkg::hex_nibble(item.in_byte)};
                    have       = 1'b1;
                    phase_next = urldec_pkg::PH_PLAIN;
                end
                default:
                begin
                    if (item.in_byte == urldec_pkg::PERCENT_CHAR) begin
                        phase_next = urldec_pkg::PH_HIGH;
                    end
                    else begin
                        value      = item.in_byte;
                        have       = 1'b1;
                        phase_next = urldec_pkg::PH_PLAIN;
                    end
                end
            endcase
        end
        if (item.is_last) begin
            phase_next = urldec_pkg::PH_PLAIN;
            high_next  = 4'h0;
        end
    end

    // Capacity check: capacity zero behaves like capacity one
    always_comb
    begin
        if (capacity == '0) begin
            limit = '0;
        end
        else begin
            limit = urldec_pkg::CMP_WIDTH'(capacity - 1'b1);
        end
        count_ext = urldec_pkg::CMP_WIDTH'(count_reg);
        full      = (count_ext >= limit) || (&count_reg);
    end

    assign emit        = have && !full;
    assign count_after = emit ? count_reg + 1'b1 : count_reg;

    // Next string state; the final byte clears it
    always_comb
    begin
        stopped_next = stopped_reg || (have && full);
        count_next   = count_after;
        if (item.is_last) begin
            count_next   = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= urldec_pkg::PH_PLAIN;
            high_reg    <= 4'h0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else if (fire) begin
            phase_reg   <= phase_next;
            high_reg    <= high_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

    // Result for this byte
    always_comb
    begin
        res_valid         = fire && (emit || item.is_last);
        res.out_byte      = emit ? value : 8'h00;
        res.byte_valid    = emit;
        res.end_of_string = item.is_last;
        res.out_length    = item.is_last ? urldec_pkg::LEN_WIDTH'(count_after) : '0;
    end

endmodule

>>> sv/urldec_out_reg.sv
module urldec_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    input  urldec_pkg::out_item_t res,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output urldec_pkg::out_item_t out_data
);

    logic                  valid_reg;
    logic                  valid_next;
    urldec_pkg::out_item_t data_reg;

    // Register is free when empty or when its beat leaves this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (free) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result beat
    always_ff @(posedge clk)
    begin
        if (free && res_valid) begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> sv/url_percent_decoder.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | in_data  (in_item_t: in_byte, is_last)
// out     | output    | out_valid/out_stall | out_data (out_item_t: out_byte, byte_valid,
//         |           |                     |           end_of_string, out_length)
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (out_capacity, always ready)
//
// One byte per cycle while out_stall is low; a taken byte passes through the input register,
// the decode logic and the result register.
// Reset clears the escape state, the byte count and both valid flags; capacity goes to 256.
// in_stall rises only while the input register is full and the result register is held
// by out_stall; a byte that yields no result still moves through the decode stage.
module url_percent_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  urldec_pkg::in_item_t                in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output urldec_pkg::out_item_t               out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [urldec_pkg::LEN_WIDTH-1:0]    cfg_data
);

    logic                                   item_valid;
    urldec_pkg::in_item_t                   item;
    logic                                   free;
    logic                                   fire;
    logic                                   res_valid;
    urldec_pkg::out_item_t                  res;
    logic [urldec_pkg::LEN_WIDTH-1:0]       capacity_reg;

    // Capacity register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg <= urldec_pkg::CAPACITY_RST;
        end
        else if (cfg_valid && cfg_ready) begin
            capacity_reg <= cfg_data;
        end
    end

    // Advance the held byte when the result register can take its beat
    assign fire = item_valid && free;

    urldec_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .take       (free),
        .item_valid (item_valid),
        .item       (item)
    );

    urldec_decode u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .capacity  (capacity_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    urldec_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> sv/urldec_checker.sv
module urldec_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input urldec_pkg::out_item_t               out_data
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Every result carries a byte or closes a string
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.byte_valid || out_data.end_of_string)
        else $error("empty result beat");

    // Unused fields read zero
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.byte_valid || out_data.out_byte == '0) &&
                      (out_data.end_of_string || out_data.out_length == '0))
        else $error("unused result field not zero");

    // A byte emitted on the final beat is counted in the length
    a_len_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_valid && out_data.end_of_string |->
            out_data.out_length != '0)
        else $error("length misses the final byte");

    // Input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without back pressure");

endmodule

bind url_percent_decoder urldec_checker u_chk (.*);
